// ===== src/pcap_pkg.sv =====
// Shared constants, types and the arctangent table of the phase-cal amplitude/phase block.
package pcap_pkg;

  localparam int COUNT_BITS_DEF   = 32;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_STEPS       = 31;
  localparam int ATAN_LEN         = 30;
  localparam int VEC_W            = 34;
  localparam int FRAC_W           = 31;

  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [13:0] PCT_SCALE    = 14'd10000;
  localparam logic [13:0] AMP_MAX      = 14'd14143;

  typedef struct packed {
    logic [31:0] bit_count;
    logic        zero_total;
    logic        count_over_total;
  } side_t;

  // atan(2^-i) in units of pi/2^31
  function automatic logic [29:0] atan_q31(input int idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'h20000000;
      1:  v = 30'h12E4051E;
      2:  v = 30'h09FB385B;
      3:  v = 30'h051111D4;
      4:  v = 30'h028B0D43;
      5:  v = 30'h0145D7E1;
      6:  v = 30'h00A2F61E;
      7:  v = 30'h00517C55;
      8:  v = 30'h0028BE53;
      9:  v = 30'h00145F2F;
      10: v = 30'h000A2F98;
      11: v = 30'h000517CC;
      12: v = 30'h00028BE6;
      13: v = 30'h000145F3;
      14: v = 30'h0000A2FA;
      15: v = 30'h0000517D;
      16: v = 30'h000028BE;
      17: v = 30'h0000145F;
      18: v = 30'h00000A30;
      19: v = 30'h00000518;
      20: v = 30'h0000028C;
      21: v = 30'h00000146;
      22: v = 30'h000000A3;
      23: v = 30'h00000051;
      24: v = 30'h00000029;
      25: v = 30'h00000014;
      26: v = 30'h0000000A;
      27: v = 30'h00000005;
      28: v = 30'h00000003;
      29: v = 30'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/pcap_if.sv =====
// Valid/ready channel interfaces for the correlator counts and the amplitude/phase words.
interface pcap_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] cos_count;
  logic [31:0] sin_count;
  logic [31:0] cos_total;
  logic [31:0] sin_total;

  modport source (output valid, cos_count, sin_count, cos_total, sin_total, input ready);
  modport sink   (input valid, cos_count, sin_count, cos_total, sin_total, output ready);
endinterface

interface pcap_out_if;
  logic               valid;
  logic               ready;
  logic [13:0]        amplitude_hundredths;
  logic signed [15:0] phase_code;
  logic [31:0]        bit_count;
  logic               zero_total;
  logic               count_over_total;

  modport source (output valid, amplitude_hundredths, phase_code, bit_count, zero_total,
                  count_over_total, input ready);
  modport sink   (input valid, amplitude_hundredths, phase_code, bit_count, zero_total,
                  count_over_total, output ready);
endinterface

// ===== src/pcap_frac.sv =====
// Pipelined restoring divider that turns each count into |2c-t|/t, one quotient bit per stage.
module pcap_frac #(
  parameter int CW = pcap_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [CW-1:0]              cos_count,
  input  logic [CW-1:0]              sin_count,
  input  logic [CW-1:0]              cos_total,
  input  logic [CW-1:0]              sin_total,
  output logic                       out_valid,
  output logic [pcap_pkg::FRAC_W-1:0] cos_q,
  output logic                       cos_neg,
  output logic [pcap_pkg::FRAC_W-1:0] sin_q,
  output logic                       sin_neg,
  output pcap_pkg::side_t            out_side
);

  localparam int NS = pcap_pkg::FRAC_STEPS;
  localparam int QW = pcap_pkg::FRAC_W;

  logic [NS:0]     vld_r;
  pcap_pkg::side_t side_r [0:NS];
  logic [CW:0]     rem_r  [0:NS][0:1];
  logic [CW-1:0]   tot_r  [0:NS][0:1];
  logic [QW-1:0]   quo_r  [0:NS][0:1];
  logic            neg_r  [0:NS][0:1];

  logic [CW-1:0]   cnt_in [0:1];
  logic [CW-1:0]   tot_in [0:1];
  logic [CW:0]     mag_nxt [0:1];
  logic            neg_nxt [0:1];
  logic [1:0]      over;
  logic [CW:0]     tsum;
  pcap_pkg::side_t side_nxt;

  logic [CW:0]     rem_nxt [1:NS][0:1];
  logic            bit_nxt [1:NS][0:1];

  always_comb begin
    logic [CW-1:0] cl;
    logic [CW:0]   twoc;
    logic [CW:0]   tt;
    cnt_in[0] = cos_count;
    cnt_in[1] = sin_count;
    tot_in[0] = cos_total;
    tot_in[1] = sin_total;
    for (int l = 0; l < 2; l++) begin
      // clamp a count that runs past its total
      over[l] = cnt_in[l] > tot_in[l];
      cl      = over[l] ? tot_in[l] : cnt_in[l];
      twoc    = {cl, 1'b0};
      tt      = {1'b0, tot_in[l]};
      neg_nxt[l] = twoc < tt;
      mag_nxt[l] = neg_nxt[l] ? (tt - twoc) : (twoc - tt);
    end
    tsum = {1'b0, cos_total} + {1'b0, sin_total};
    side_nxt.bit_count        = 32'(tsum[CW:1]);
    side_nxt.zero_total       = (cos_total == '0) || (sin_total == '0);
    side_nxt.count_over_total = |over;
  end

  always_comb begin
    logic [CW:0] diff;
    for (int k = 1; k <= NS; k++) begin
      for (int l = 0; l < 2; l++) begin
        bit_nxt[k][l] = rem_r[k-1][l] >= {1'b0, tot_r[k-1][l]};
        diff = bit_nxt[k][l] ? (rem_r[k-1][l] - {1'b0, tot_r[k-1][l]}) : rem_r[k-1][l];
        rem_nxt[k][l] = {diff[CW-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_nxt;
      for (int l = 0; l < 2; l++) begin
        rem_r[0][l] <= mag_nxt[l];
        tot_r[0][l] <= tot_in[l];
        quo_r[0][l] <= '0;
        neg_r[0][l] <= neg_nxt[l];
      end
      for (int k = 1; k <= NS; k++) begin
        side_r[k] <= side_r[k-1];
        for (int l = 0; l < 2; l++) begin
          rem_r[k][l] <= rem_nxt[k][l];
          tot_r[k][l] <= tot_r[k-1][l];
          quo_r[k][l] <= {quo_r[k-1][l][QW-2:0], bit_nxt[k][l]};
          neg_r[k][l] <= neg_r[k-1][l];
        end
      end
    end
  end

  assign out_valid = vld_r[NS];
  assign cos_q     = quo_r[NS][0];
  assign cos_neg   = neg_r[NS][0];
  assign sin_q     = quo_r[NS][1];
  assign sin_neg   = neg_r[NS][1];
  assign out_side  = side_r[NS];

endmodule

// ===== src/pcap_cordic.sv =====
// Vectoring CORDIC pipeline: quadrant fold, then one micro-rotation per stage.
module pcap_cordic #(
  parameter int STEPS = pcap_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic [pcap_pkg::FRAC_W-1:0]       cos_q,
  input  logic                              cos_neg,
  input  logic [pcap_pkg::FRAC_W-1:0]       sin_q,
  input  logic                              sin_neg,
  input  pcap_pkg::side_t                   in_side,
  output logic                              out_valid,
  output logic signed [pcap_pkg::VEC_W-1:0] x_out,
  output logic signed [pcap_pkg::VEC_W-1:0] ang_out,
  output pcap_pkg::side_t                   out_side
);

  localparam int VW = pcap_pkg::VEC_W;

  logic [STEPS:0]       vld_r;
  pcap_pkg::side_t      side_r [0:STEPS];
  logic signed [VW-1:0] x_r    [0:STEPS];
  logic signed [VW-1:0] y_r    [0:STEPS];
  logic signed [VW-1:0] ang_r  [0:STEPS];

  logic signed [VW-1:0] x0_nxt, y0_nxt, a0_nxt;
  logic signed [VW-1:0] x_nxt [1:STEPS];
  logic signed [VW-1:0] y_nxt [1:STEPS];
  logic signed [VW-1:0] a_nxt [1:STEPS];

  always_comb begin
    logic signed [VW-1:0] xs, ys;
    xs = signed'(VW'(cos_q));
    ys = signed'(VW'(sin_q));
    if (cos_neg) xs = -xs;
    if (sin_neg) ys = -ys;
    // fold the left half plane into the right one
    if (xs < 0) begin
      if (ys >= 0) begin
        x0_nxt = ys;
        y0_nxt = -xs;
        a0_nxt = signed'(VW'(1) <<< 30);
      end else begin
        x0_nxt = -ys;
        y0_nxt = xs;
        a0_nxt = -signed'(VW'(1) <<< 30);
      end
    end else begin
      x0_nxt = xs;
      y0_nxt = ys;
      a0_nxt = '0;
    end
  end

  always_comb begin
    logic signed [VW-1:0] dx, dy, at;
    for (int k = 1; k <= STEPS; k++) begin
      dx = y_r[k-1] >>> (k-1);
      dy = x_r[k-1] >>> (k-1);
      at = signed'(VW'(pcap_pkg::atan_q31(k-1)));
      if (y_r[k-1] >= 0) begin
        x_nxt[k] = x_r[k-1] + dx;
        y_nxt[k] = y_r[k-1] - dy;
        a_nxt[k] = ang_r[k-1] + at;
      end else begin
        x_nxt[k] = x_r[k-1] - dx;
        y_nxt[k] = y_r[k-1] + dy;
        a_nxt[k] = ang_r[k-1] - at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      ang_r[0]  <= a0_nxt;
      for (int k = 1; k <= STEPS; k++) begin
        side_r[k] <= side_r[k-1];
        x_r[k]    <= x_nxt[k];
        y_r[k]    <= y_nxt[k];
        ang_r[k]  <= a_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[STEPS];
  assign x_out     = x_r[STEPS];
  assign ang_out   = ang_r[STEPS];
  assign out_side  = side_r[STEPS];

endmodule

// ===== src/pcap_scale.sv =====
// Gain correction, percent scaling, phase rounding and result register.
module pcap_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic signed [pcap_pkg::VEC_W-1:0] x_in,
  input  logic signed [pcap_pkg::VEC_W-1:0] ang_in,
  input  pcap_pkg::side_t                   in_side,
  output logic                              out_valid,
  output logic [13:0]                       amplitude,
  output logic signed [15:0]                phase,
  output pcap_pkg::side_t                   out_side
);

  localparam int VW = pcap_pkg::VEC_W;

  logic [2:0]        vld_r;
  pcap_pkg::side_t   side1_r, side2_r, side3_r;
  logic [32:0]       q1_r;
  logic [15:0]       ph1_r, ph2_r, ph3_r;
  logic [17:0]       raw2_r;
  logic [13:0]       amp3_r;

  logic [32:0]       ux;
  logic [63:0]       p1;
  logic [VW-1:0]     ph_sum;
  logic [47:0]       p2;
  logic [13:0]       amp_cl;

  assign ux     = (x_in > 0) ? x_in[32:0] : '0;
  assign p1     = 64'(ux) * 64'(pcap_pkg::INV_GAIN_Q30) + (64'd1 << 29);
  assign ph_sum = ang_in + VW'(32768);
  assign p2     = 48'(q1_r) * 48'(pcap_pkg::PCT_SCALE) + (48'd1 << 29);
  assign amp_cl = (raw2_r > 18'(pcap_pkg::AMP_MAX)) ? pcap_pkg::AMP_MAX : raw2_r[13:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_r    <= p1[62:30];
      ph1_r   <= ph_sum[31:16];
      side1_r <= in_side;
      raw2_r  <= p2[47:30];
      ph2_r   <= ph1_r;
      side2_r <= side1_r;
      // force zeros when a total was empty
      amp3_r  <= side2_r.zero_total ? '0 : amp_cl;
      ph3_r   <= side2_r.zero_total ? '0 : ph2_r;
      side3_r <= side2_r;
    end
  end

  assign out_valid = vld_r[2];
  assign amplitude = amp3_r;
  assign phase     = signed'(ph3_r);
  assign out_side  = side3_r;

endmodule

// ===== src/phase_cal_amp_phase_top.sv =====
// Phase-cal channel amplitude and phase: divider, CORDIC and scaling pipeline.
//
// Takes one word of correlator counts per cycle while the result word is not stalled, and returns
// the vector magnitude in 0.01 percent units, the phase in pi/32768 units and the average bit
// count. The pipeline is made of the divider's load stage and its 31 quotient-bit stages, the
// quadrant fold and the CORDIC_STEPS micro-rotation stages, and the three scaling stages. The
// pipeline holds as a whole while the result word is not taken; it needs no clearing after
// reset.
module phase_cal_amp_phase_top #(
  parameter int COUNT_BITS   = pcap_pkg::COUNT_BITS_DEF,
  parameter int CORDIC_STEPS = pcap_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pcap_in_if.sink     in_ch,
  pcap_out_if.source  out_ch
);

  localparam int VW = pcap_pkg::VEC_W;
  localparam int QW = pcap_pkg::FRAC_W;

  logic adv;

  logic                 f_valid, f_cneg, f_sneg;
  logic [QW-1:0]        f_cq, f_sq;
  pcap_pkg::side_t      f_side;

  logic                 c_valid;
  logic signed [VW-1:0] c_x, c_ang;
  pcap_pkg::side_t      c_side;

  pcap_pkg::side_t      s_side;

  // advance everything unless the result word is stalled
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  pcap_frac #(.CW(COUNT_BITS)) u_frac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_ch.valid),
    .cos_count (COUNT_BITS'(in_ch.cos_count)),
    .sin_count (COUNT_BITS'(in_ch.sin_count)),
    .cos_total (COUNT_BITS'(in_ch.cos_total)),
    .sin_total (COUNT_BITS'(in_ch.sin_total)),
    .out_valid (f_valid),
    .cos_q     (f_cq),
    .cos_neg   (f_cneg),
    .sin_q     (f_sq),
    .sin_neg   (f_sneg),
    .out_side  (f_side)
  );

  pcap_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f_valid),
    .cos_q     (f_cq),
    .cos_neg   (f_cneg),
    .sin_q     (f_sq),
    .sin_neg   (f_sneg),
    .in_side   (f_side),
    .out_valid (c_valid),
    .x_out     (c_x),
    .ang_out   (c_ang),
    .out_side  (c_side)
  );

  pcap_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (c_valid),
    .x_in      (c_x),
    .ang_in    (c_ang),
    .in_side   (c_side),
    .out_valid (out_ch.valid),
    .amplitude (out_ch.amplitude_hundredths),
    .phase     (out_ch.phase_code),
    .out_side  (s_side)
  );

  assign out_ch.bit_count        = s_side.bit_count;
  assign out_ch.zero_total       = s_side.zero_total;
  assign out_ch.count_over_total = s_side.count_over_total;

`ifndef SYNTHESIS
  a_zero_forced: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_total |->
      out_ch.amplitude_hundredths == '0 && out_ch.phase_code == '0)
    else $error("amplitude or phase not zero for an empty total");

  a_amp_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.amplitude_hundredths <= pcap_pkg::AMP_MAX)
    else $error("amplitude above limit");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while the result word is stalled");
`endif

endmodule
